// File: rtl/radix64_text_decoder_macros.svh
// Assertion helpers, clocked on clk, reset rst.
`ifndef RADIX64_TEXT_DECODER_MACROS_SVH
`define RADIX64_TEXT_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define RTD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rtd assertion failed");
`define RTD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rtd assertion failed");
`else
`define RTD_ASSERT(label, prop)
`define RTD_ASSERT_ALWAYS(label, prop)
`endif

`endif

// File: rtl/rtd_pkg.sv
`default_nettype none
package rtd_pkg;

  localparam logic [7:0] SYM_INVALID = 8'hff;
  localparam logic [7:0] SYM_SKIP    = 8'hfe;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // indexed by symbols in the open group
  localparam logic [1:0] BYTES_FOR_COUNT [4] = '{2'd0, 2'd0, 2'd1, 2'd2};
  localparam logic [3:0] PAD_FOR_COUNT   [4] = '{4'd0, 4'd0, 4'd12, 4'd6};

  typedef enum logic [1:0] {
    ST_RUN = 2'd0,
    ST_END = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  // one request from front to back: up to three bytes plus closing status
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    status_t     status;
  } job_t;

  function automatic logic [7:0] map_char(input logic [7:0] c);
    logic [7:0] s;
    s = SYM_INVALID;
    if (c == 8'h2d) s = 8'd0;
    else if (c inside {[8'h30:8'h39]}) s = c - 8'h2f;
    else if (c inside {[8'h41:8'h5a]}) s = c - 8'h36;
    else if (c == 8'h5f) s = 8'd37;
    else if (c inside {[8'h61:8'h7a]}) s = c - 8'h3b;
    else if (c inside {8'h09, 8'h0a, 8'h0d, 8'h20}) s = SYM_SKIP;
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/rtd_char_if.sv
`default_nettype none
interface rtd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_source;

  modport source (output valid, output char_code, output end_of_source, input ready);
  modport sink   (input valid, input char_code, input end_of_source, output ready);
endinterface
`default_nettype wire

// File: rtl/rtd_byte_if.sv
`default_nettype none
interface rtd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output data_byte, output byte_valid, output status,
                  output last, input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input status,
                  input last, output ready);
endinterface
`default_nettype wire

// File: rtl/rtd_front.sv
`default_nettype none
module rtd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  rtd_char_if.sink           chars,
  output logic               push_valid,
  output rtd_pkg::job_t      push_data,
  input  wire logic          push_ready
);

  logic [17:0] acc;
  logic [17:0] acc_next;
  logic [1:0]  count;
  logic [1:0]  count_next;

  logic [7:0]  sym;
  logic        is_bad;
  logic        is_skip;
  logic        completes;
  logic [23:0] acc_sh;
  logic [17:0] acc_mid;
  logic [1:0]  cnt_mid;
  logic [23:0] word_flush;
  logic        emit;
  logic        accept;

  always_comb begin
    sym        = rtd_pkg::map_char(chars.char_code);
    is_bad     = (sym == rtd_pkg::SYM_INVALID);
    is_skip    = (sym == rtd_pkg::SYM_SKIP);
    acc_sh     = {acc, sym[5:0]};
    completes  = !is_bad && !is_skip && (count == 2'd3);
    acc_mid    = is_skip ? acc : acc_sh[17:0];
    cnt_mid    = is_skip ? count : count + 2'd1;
    word_flush = 24'({6'b0, acc_mid} << rtd_pkg::PAD_FOR_COUNT[cnt_mid]);

    emit       = 1'b1;
    push_data  = '{word: 24'd0, nbytes: 2'd0, status: rtd_pkg::ST_BAD};
    acc_next   = 18'd0;
    count_next = 2'd0;
    if (is_bad) begin
      push_data.status = rtd_pkg::ST_BAD;
    end else if (completes) begin
      push_data.word   = acc_sh;
      push_data.nbytes = 2'd3;
      push_data.status = chars.end_of_source ? rtd_pkg::ST_END : rtd_pkg::ST_RUN;
    end else if (chars.end_of_source) begin
      push_data.word   = word_flush;
      push_data.nbytes = rtd_pkg::BYTES_FOR_COUNT[cnt_mid];
      push_data.status = rtd_pkg::ST_END;
    end else begin
      emit       = 1'b0;
      acc_next   = acc_mid;
      count_next = cnt_mid;
    end
  end

  assign chars.ready = push_ready;
  assign push_valid  = chars.valid && emit;
  assign accept      = chars.valid && chars.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= 18'd0;
      count <= 2'd0;
    end else if (accept) begin
      acc   <= acc_next;
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rtd_queue.sv
`default_nettype none
`include "radix64_text_decoder_macros.svh"
module rtd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  input  rtd_pkg::job_t      push_data,
  output logic               push_ready,
  output logic               head_valid,
  output rtd_pkg::job_t      head_data,
  input  wire logic          pop
);

  rtd_pkg::job_t                  entries [rtd_pkg::QUEUE_DEPTH];
  logic [rtd_pkg::QPTR_W-1:0]     wr_ptr;
  logic [rtd_pkg::QPTR_W-1:0]     rd_ptr;
  logic [rtd_pkg::QCNT_W-1:0]     count;
  logic                           do_push;
  logic                           do_pop;

  localparam logic [rtd_pkg::QPTR_W-1:0] PTR_LAST = rtd_pkg::QPTR_W'(rtd_pkg::QUEUE_DEPTH - 1);
  localparam logic [rtd_pkg::QCNT_W-1:0] CNT_FULL = rtd_pkg::QCNT_W'(rtd_pkg::QUEUE_DEPTH);

  assign push_ready = (count != CNT_FULL);
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `RTD_ASSERT(a_count_bound, count <= CNT_FULL)
  `RTD_ASSERT(a_pop_nonempty, pop |-> head_valid)
  `RTD_ASSERT_ALWAYS(a_reset_empty, rst |=> (count == '0) && (wr_ptr == rd_ptr))

endmodule
`default_nettype wire

// File: rtl/rtd_back.sv
`default_nettype none
`include "radix64_text_decoder_macros.svh"
module rtd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  rtd_pkg::job_t      head_data,
  output logic               pop,
  rtd_byte_if.source         results
);

  logic [1:0] idx;
  logic [1:0] last_idx;
  logic       is_last;
  logic       load;
  logic [7:0] sel_byte;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic [1:0] out_status;
  logic       out_last;

  always_comb begin
    last_idx = (head_data.nbytes == 2'd0) ? 2'd0 : head_data.nbytes - 2'd1;
    is_last  = (idx == last_idx);
    case (idx)
      2'd0:    sel_byte = head_data.word[23:16];
      2'd1:    sel_byte = head_data.word[15:8];
      default: sel_byte = head_data.word[7:0];
    endcase
  end

  assign load = head_valid && (!out_valid || results.ready);
  assign pop  = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= is_last ? 2'd0 : idx + 2'd1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_valid <= (head_data.nbytes != 2'd0);
      out_byte       <= (head_data.nbytes != 2'd0) ? sel_byte : 8'd0;
      out_last       <= is_last;
      out_status     <= is_last ? head_data.status : rtd_pkg::ST_RUN;
    end
  end

  assign results.valid      = out_valid;
  assign results.data_byte  = out_byte;
  assign results.byte_valid = out_byte_valid;
  assign results.status     = out_status;
  assign results.last       = out_last;

  `RTD_ASSERT(a_nobyte_is_last, out_valid && !out_byte_valid |-> out_last)
  `RTD_ASSERT(a_status_on_last, out_valid && !out_last |-> out_status == rtd_pkg::ST_RUN)
  `RTD_ASSERT(a_nobyte_closes, out_valid && !out_byte_valid |-> out_status != rtd_pkg::ST_RUN)

endmodule
`default_nettype wire

// File: rtl/radix64_text_decoder.sv
// channel   dir  payload                                     handshake
// chars     in   char_code[7:0], end_of_source               valid/ready
// results   out  data_byte[7:0], byte_valid, status[1:0],    valid/ready
//                last
//
// One character accepted per cycle while the queue has room; the back end
// sends one result per cycle unless results.ready stalls it, so a group of
// four characters gives three results, through the queue and output register.
// chars.ready drops only when the two-entry request queue is full.
// rst is synchronous: clears accumulator, symbol count, queue and output valid.
`default_nettype none
module radix64_text_decoder (
  input  wire logic   clk,
  input  wire logic   rst,
  rtd_char_if.sink    chars,
  rtd_byte_if.source  results
);

  logic               push_valid;
  logic               push_ready;
  rtd_pkg::job_t      push_data;
  logic               head_valid;
  rtd_pkg::job_t      head_data;
  logic               pop;

  rtd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  rtd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  rtd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .results    (results)
  );

endmodule
`default_nettype wire
